### hw/rtl/dtls_pkg.sv
// ----------------------------------------------------------------------------
// dtls_pkg
// Shared widths, fixed-point format, line record and fraction weight table
// for the decimal text line summer.
// ----------------------------------------------------------------------------
`default_nettype none

package dtls_pkg;

  // Result format: signed Q(63-FracBits).FracBits in a 64-bit word
  localparam int unsigned FracBits      = 32;
  localparam int unsigned MaxFracDigits = 9;

  localparam int unsigned WordW    = 64;
  localparam int unsigned IntW     = 31;  // integer part, saturates at 2^31-1
  localparam int unsigned FracAccW = 33;  // fraction sum in units of 2^-32
  localparam int unsigned PosW     = 4;   // fraction digits taken, 0..9
  localparam int unsigned ByteW    = 8;

  typedef logic signed [WordW-1:0] word_t;

  // Parsed line handed from the parser to the value stage
  typedef struct packed {
    logic                neg;
    logic [IntW-1:0]     int_part;
    logic [FracAccW-1:0] frac;
    logic                eot;
  } line_t;

  // round(2^32 / 10^(k+1)), weight of fraction digit k+1
  function automatic logic [FracAccW-1:0] pow10_neg(input logic [PosW-1:0] k);
    logic [FracAccW-1:0] w;
    unique case (k)
      4'd0:    w = FracAccW'(429496730);
      4'd1:    w = FracAccW'(42949673);
      4'd2:    w = FracAccW'(4294967);
      4'd3:    w = FracAccW'(429497);
      4'd4:    w = FracAccW'(42950);
      4'd5:    w = FracAccW'(4295);
      4'd6:    w = FracAccW'(429);
      4'd7:    w = FracAccW'(43);
      4'd8:    w = FracAccW'(4);
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/dtls_parse.sv
// ----------------------------------------------------------------------------
// dtls_parse
// Input register and per-byte parser: sign, integer digits, point and
// fraction digits. Hands a finished line to the value stage.
// ----------------------------------------------------------------------------
`default_nettype none

module dtls_parse (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [dtls_pkg::ByteW-1:0] text_byte_i,
  input  wire logic                       end_of_text_i,
  output logic                            line_valid_o,
  input  wire logic                       line_free_i,
  output dtls_pkg::line_t                 line_o
);
  import dtls_pkg::*;

  localparam logic [1:0] PhSkip = 2'd0;
  localparam logic [1:0] PhInt  = 2'd1;
  localparam logic [1:0] PhFrac = 2'd2;
  localparam logic [1:0] PhDone = 2'd3;

  localparam logic [ByteW-1:0] ChZero    = 8'h30;
  localparam logic [ByteW-1:0] ChNine    = 8'h39;
  localparam logic [ByteW-1:0] ChMinus   = 8'h2d;
  localparam logic [ByteW-1:0] ChPoint   = 8'h2e;
  localparam logic [ByteW-1:0] ChNewline = 8'h0a;

  localparam int unsigned MulW = IntW + 4;

  logic             in_v_q;
  logic [ByteW-1:0] byte_q;
  logic             eot_q;

  logic [1:0]          ph_q, ph_d;
  logic                neg_q, neg_d;
  logic [IntW-1:0]     int_q, int_d;
  logic [FracAccW-1:0] frac_q, frac_d;
  logic [PosW-1:0]     pos_q, pos_d;

  logic  line_v_q;
  line_t line_q;

  logic                num_char, is_nl, emit, fire;
  logic [3:0]          digit;
  logic [MulW-1:0]     int_sum;
  logic [IntW-1:0]     int_sat;
  logic [FracAccW-1:0] frac_prod;
  logic                pos_room;

  assign is_nl    = (byte_q == ChNewline);
  assign num_char = (byte_q >= ChZero) && (byte_q <= ChNine);
  assign digit    = byte_q[3:0];

  // x10 as shift-add, then saturate to 31 bits
  assign int_sum = (MulW'(int_q) << 3) + (MulW'(int_q) << 1) + MulW'(digit);
  assign int_sat = (|int_sum[MulW-1:IntW]) ? '1 : int_sum[IntW-1:0];

  assign frac_prod = FracAccW'(digit) * pow10_neg(pos_q);
  assign pos_room  = (pos_q < PosW'(MaxFracDigits));

  always_comb begin
    ph_d   = ph_q;
    neg_d  = neg_q;
    int_d  = int_q;
    frac_d = frac_q;
    pos_d  = pos_q;
    if (!is_nl) begin
      unique case (ph_q)
        PhSkip: begin
          if (byte_q == ChMinus) begin
            neg_d = 1'b1;
            ph_d  = PhInt;
          end else if (num_char) begin
            int_d = int_sat;
            ph_d  = PhInt;
          end
        end
        PhInt: begin
          if (num_char) begin
            int_d = int_sat;
          end else if (byte_q == ChPoint) begin
            ph_d = PhFrac;
          end else begin
            ph_d = PhDone;
          end
        end
        PhFrac: begin
          if (num_char) begin
            if (pos_room) begin
              frac_d = frac_q + frac_prod;
              pos_d  = pos_q + PosW'(1);
            end
          end else begin
            ph_d = PhDone;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign emit       = is_nl || eot_q;
  assign fire       = in_v_q && (!emit || line_free_i);
  assign in_stall_o = in_v_q && !fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q   <= 1'b0;
      ph_q     <= PhSkip;
      neg_q    <= 1'b0;
      int_q    <= '0;
      frac_q   <= '0;
      pos_q    <= '0;
      line_v_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_v_q <= in_valid_i;
      end
      if (fire) begin
        if (emit) begin
          ph_q   <= PhSkip;
          neg_q  <= 1'b0;
          int_q  <= '0;
          frac_q <= '0;
          pos_q  <= '0;
        end else begin
          ph_q   <= ph_d;
          neg_q  <= neg_d;
          int_q  <= int_d;
          frac_q <= frac_d;
          pos_q  <= pos_d;
        end
      end
      if (line_free_i) begin
        line_v_q <= fire && emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      byte_q <= text_byte_i;
      eot_q  <= end_of_text_i;
    end
    if (fire && emit) begin
      line_q.neg      <= neg_d;
      line_q.int_part <= int_d;
      line_q.frac     <= frac_d;
      line_q.eot      <= eot_q;
    end
  end

  assign line_valid_o = line_v_q;
  assign line_o       = line_q;

  // a line close leaves a clean parser behind
  a_clear_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && emit) |=> (ph_q == PhSkip && pos_q == '0 && frac_q == '0))
    else $error("parser not cleared after line close");

  a_skip_is_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q == PhSkip) |-> (!neg_q && int_q == '0 && frac_q == '0))
    else $error("number state set while still skipping");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosW'(MaxFracDigits))
    else $error("fraction digit count past limit");

endmodule

`default_nettype wire

### hw/rtl/dtls_value.sv
// ----------------------------------------------------------------------------
// dtls_value
// Builds the signed fixed-point value of a parsed line: integer and fraction
// joined, magnitude clamped, sign applied.
// ----------------------------------------------------------------------------
`default_nettype none

module dtls_value (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            line_valid_i,
  output logic                 line_free_o,
  input  wire dtls_pkg::line_t line_i,
  output logic                 val_valid_o,
  input  wire logic            val_free_i,
  output dtls_pkg::word_t      val_o,
  output logic                 val_eot_o
);
  import dtls_pkg::*;

  localparam int unsigned FracShift = 32 - FracBits;
  localparam logic [WordW-1:0] MagMax = {1'b0, {(WordW-1){1'b1}}};

  logic [FracAccW-1:0] frac_sh;
  logic [WordW:0]      mag_wide;
  logic [WordW-1:0]    mag, value;

  logic             val_v_q;
  logic [WordW-1:0] val_q;
  logic             eot_q;
  logic             val_adv;

  assign frac_sh  = line_i.frac >> FracShift;
  assign mag_wide = ((WordW+1)'(line_i.int_part) << FracBits) + (WordW+1)'(frac_sh);
  assign mag      = (|mag_wide[WordW:WordW-1]) ? MagMax : mag_wide[WordW-1:0];
  assign value    = line_i.neg ? (WordW'(0) - mag) : mag;

  // value register loads when empty or when its line moves on
  assign val_adv     = !val_v_q || val_free_i;
  assign line_free_o = !line_valid_i || val_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_v_q <= 1'b0;
    end else if (val_adv) begin
      val_v_q <= line_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (val_adv && line_valid_i) begin
      val_q <= value;
      eot_q <= line_i.eot;
    end
  end

  assign val_valid_o = val_v_q;
  assign val_o       = word_t'(val_q);
  assign val_eot_o   = eot_q;

  a_val_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (val_v_q && !val_free_i) |=> (val_v_q && $stable(val_q)))
    else $error("value stage dropped a held line");

endmodule

`default_nettype wire

### hw/rtl/dtls_sum.sv
// ----------------------------------------------------------------------------
// dtls_sum
// Saturating running sum of line values and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dtls_sum (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            val_valid_i,
  output logic                 val_free_o,
  input  wire dtls_pkg::word_t val_i,
  input  wire logic            val_eot_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output dtls_pkg::word_t      line_value_o,
  output dtls_pkg::word_t      running_sum_o,
  output logic                 is_final_o
);
  import dtls_pkg::*;

  localparam logic [WordW-1:0] SumMax = {1'b0, {(WordW-1){1'b1}}};
  localparam logic [WordW-1:0] SumMin = {1'b1, {(WordW-1){1'b0}}};

  logic [WordW-1:0] total_q;
  logic             out_v_q;
  logic [WordW-1:0] value_q, sum_q;
  logic             final_q;

  logic [WordW-1:0] addend, sum_raw, sum_sat;
  logic             ovf, out_free, take;

  assign addend  = WordW'(val_i);
  assign sum_raw = total_q + addend;
  assign ovf     = (total_q[WordW-1] == addend[WordW-1]) &&
                   (sum_raw[WordW-1] != total_q[WordW-1]);
  assign sum_sat = ovf ? (total_q[WordW-1] ? SumMin : SumMax) : sum_raw;

  assign out_free   = !out_v_q || !out_stall_i;
  assign take       = val_valid_i && out_free;
  assign val_free_o = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (out_free) begin
        out_v_q <= val_valid_i;
      end
      if (take) begin
        // end of text starts a fresh sum
        total_q <= val_eot_i ? '0 : sum_sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      value_q <= addend;
      sum_q   <= sum_sat;
      final_q <= val_eot_i;
    end
  end

  assign out_valid_o   = out_v_q;
  assign line_value_o  = word_t'(value_q);
  assign running_sum_o = word_t'(sum_q);
  assign is_final_o    = final_q;

  a_sum_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && val_eot_i) |=> (total_q == '0))
    else $error("running sum not cleared after end of text");

endmodule

`default_nettype wire

### hw/rtl/decimal_text_line_summer.sv
// ----------------------------------------------------------------------------
// decimal_text_line_summer
// Parses one decimal number per text line into signed Q31.32 and reports
// each line's value with a saturating running sum.
//
//   channel | dir | handshake                 | payload
//   --------+-----+---------------------------+-----------------------------
//   in      | in  | in_valid_i / in_stall_o   | text_byte_i, end_of_text_i
//   out     | out | out_valid_o / out_stall_i | line_value_o, running_sum_o,
//           |     |                           | is_final_o
//
// One byte per cycle while the input is not stalled; the parser state and the
// running sum are the only loops, and the parser state is updated once per byte.
// A line result reaches the output after its closing byte is accepted, through
// the input reg, line reg, value reg and result reg in that order.
// Reset clears the parser, the running sum and all valid flags.
// A stalled output backs up through free stages; input stalls only when a
// line-closing byte finds every stage ahead of it occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_text_line_summer (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [dtls_pkg::ByteW-1:0] text_byte_i,
  input  wire logic                       end_of_text_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output dtls_pkg::word_t                 line_value_o,
  output dtls_pkg::word_t                 running_sum_o,
  output logic                            is_final_o
);
  import dtls_pkg::*;

  logic  line_valid, line_free;
  line_t line;
  logic  val_valid, val_free, val_eot;
  word_t val;

  dtls_parse u_parse (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .line_valid_o  (line_valid),
    .line_free_i   (line_free),
    .line_o        (line)
  );

  dtls_value u_value (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .line_valid_i (line_valid),
    .line_free_o  (line_free),
    .line_i       (line),
    .val_valid_o  (val_valid),
    .val_free_i   (val_free),
    .val_o        (val),
    .val_eot_o    (val_eot)
  );

  dtls_sum u_sum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .val_valid_i   (val_valid),
    .val_free_o    (val_free),
    .val_i         (val),
    .val_eot_i     (val_eot),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .line_value_o  (line_value_o),
    .running_sum_o (running_sum_o),
    .is_final_o    (is_final_o)
  );

endmodule

`default_nettype wire
